// ===== hw/rtl/rbb_pkg.sv =====
// Package for the RGB box blur core: constants, register indexes and queue entry type.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package rbb_pkg;
  localparam int MaxRadius  = 7;
  localparam int MaxWidth   = 1024;
  localparam int HeightLim  = 4096;
  localparam int StoreDepth = 2 * MaxRadius * MaxWidth + 2 * MaxRadius + 1;
  localparam int AddrW      = $clog2(StoreDepth);

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Work handed from the front end to the back end: store a pixel, emit an output, or both.
  typedef struct packed {
    logic        wr;
    logic [AddrW-1:0] addr;
    logic [23:0] pix;
    logic        emit;
  } rbb_job_t;
endpackage

// ===== hw/rtl/rbb_if.sv =====
// Valid/ready channel interfaces for the RGB box blur core.
// Depends on nothing.
`timescale 1ns / 1ps
interface rbb_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
  modport sink (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

interface rbb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [9:0]  out_column;
  logic [11:0] out_row;
  logic        frame_end;
  modport source (output valid, out_red, out_green, out_blue, out_column, out_row,
                  frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_column, out_row,
                frame_end, output ready);
endinterface

interface rbb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rgb_box_blur_filter_core.sv =====
// RGB box blur core: a front end classifies each word and a back end works out window means.
// A word that gives a result holds the back end while it reads each window tap through the
// single read port of the pixel store and accumulates it, runs the bit-serial divider, loads
// the output, hands it over to a ready receiver and then takes the next job; a word that only
// stores a pixel is stored as the idle back end takes it. The two-entry queue between front
// and back end lets up to two words wait. Results lag inputs by radius*width+radius words;
// flush words drain them. The input pauses for the cycle after a register write.
`timescale 1ns / 1ps
module rgb_box_blur_filter_core (
  input logic clk,
  input logic rst_n,
  rbb_in_if.sink    in_ch,
  rbb_out_if.source out_ch,
  rbb_cfg_if.sink   cfg_ch
);
  import rbb_pkg::*;
  rbb_job_t fj, bj;
  logic fv, fr, bv, br, restart;
  logic [2:0] radius; logic [10:0] width; logic [12:0] height;

  assign cfg_ch.ready = 1'b1;

  rbb_front u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_req_type(in_ch.req_type), .in_pix({in_ch.in_red, in_ch.in_green, in_ch.in_blue}),
    .cfg_valid(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .job_valid(fv), .job_ready(fr), .job(fj),
    .radius, .width, .height, .restart
  );
  rbb_queue u_queue (
    .clk, .rst_n, .flush(restart), .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(bv), .rd_ready(br), .rd_data(bj)
  );
  rbb_back u_back (
    .clk, .rst_n, .restart, .job_valid(bv), .job_ready(br), .job(bj),
    .radius, .width, .height,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_red(out_ch.out_red),
    .out_green(out_ch.out_green), .out_blue(out_ch.out_blue),
    .out_column(out_ch.out_column), .out_row(out_ch.out_row), .frame_end(out_ch.frame_end)
  );
endmodule

// ===== hw/rtl/rbb_front.sv =====
// Front end: registers, input position tracking and classification of each word.
// Depends on rbb_pkg.
`timescale 1ns / 1ps
module rbb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [23:0]       in_pix,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  output logic              job_valid,
  input  logic              job_ready,
  output rbb_pkg::rbb_job_t job,
  output logic [2:0]        radius,
  output logic [10:0]       width,
  output logic [12:0]       height,
  output logic              restart
);
  import rbb_pkg::*;
  logic [2:0]  radius_r;
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [22:0] in_lin_r, in_lin_nxt;
  logic [22:0] em_pend_r, em_pend_nxt; // emits issued (front count)
  logic [AddrW-1:0] addr_r;
  logic [22:0] total, lag;
  logic        cfg_hold_r;
  logic        is_pix, do_emit, do_any, frame_done;

  always_comb begin
    radius = (radius_r > 3'(MaxRadius)) ? 3'(MaxRadius) : radius_r;
    width  = (width_r == 11'd0) ? 11'd1 : (width_r > 11'(MaxWidth) ? 11'(MaxWidth) : width_r);
    height = (height_r == 13'd0) ? 13'd1 :
             (height_r > 13'(HeightLim) ? 13'(HeightLim) : height_r);
  end

  // Registered products keep the multipliers off the item path.
  always_ff @(posedge clk) begin
    total <= 23'(width) * 23'(height);
    lag   <= 23'(radius) * 23'(width) + 23'(radius);
  end

  // The input waits in the cycle after a register write so that the products above catch up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_hold_r <= 1'b0;
    end else begin
      cfg_hold_r <= restart;
    end
  end

  assign restart  = cfg_valid && (cfg_index inside {REG_RADIUS, REG_WIDTH, REG_HEIGHT});
  assign in_ready = job_ready && !cfg_valid && !cfg_hold_r;
  always_comb begin
    is_pix  = !in_req_type && (in_lin_r < total);
    do_emit = is_pix ? ((in_lin_r + 23'd1) > em_pend_r + lag) :
              ((in_lin_r >= total) && (em_pend_r < total));
    do_any  = is_pix || do_emit;
    frame_done = do_emit && ((em_pend_r + 23'd1) == total);
    job_valid = in_valid && !cfg_valid && !cfg_hold_r && do_any;
    job.wr   = is_pix;
    job.addr = addr_r;
    job.pix  = in_pix;
    job.emit = do_emit;
    in_lin_nxt  = in_lin_r;
    em_pend_nxt = em_pend_r;
    if (in_valid && in_ready) begin
      if (frame_done) begin
        in_lin_nxt  = '0;
        em_pend_nxt = '0;
      end else begin
        if (is_pix) in_lin_nxt = in_lin_r + 23'd1;
        if (do_emit) em_pend_nxt = em_pend_r + 23'd1;
      end
    end
  end

  // The frame ends on the word that issues its final emit; the next pixel starts a new one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 3'd1; width_r <= 11'd1024; height_r <= 13'd1024;
      in_lin_r <= '0; em_pend_r <= '0; addr_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS: radius_r <= cfg_data[2:0];
        REG_WIDTH:  width_r  <= cfg_data[10:0];
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
      if (restart) begin
        in_lin_r <= '0; em_pend_r <= '0; addr_r <= '0;
      end
    end else begin
      in_lin_r  <= in_lin_nxt;
      em_pend_r <= em_pend_nxt;
      if (in_valid && in_ready) begin
        if (frame_done)
          addr_r <= '0;
        else if (is_pix)
          addr_r <= (addr_r == AddrW'(StoreDepth - 1)) ? '0 : addr_r + 1'b1;
      end
    end
  end
endmodule

// ===== hw/rtl/rbb_queue.sv =====
// Two-entry queue between front and back end of the box blur core.
// Depends on rbb_pkg.
`timescale 1ns / 1ps
module rbb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              flush,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  rbb_pkg::rbb_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output rbb_pkg::rbb_job_t rd_data
);
  import rbb_pkg::*;
  rbb_job_t  mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

// ===== hw/rtl/rbb_back.sv =====
// Back end: pixel store and sequencer that walks the window and divides the sums.
// Depends on rbb_pkg.
`timescale 1ns / 1ps
module rbb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic              job_valid,
  output logic              job_ready,
  input  rbb_pkg::rbb_job_t job,
  input  logic [2:0]        radius,
  input  logic [10:0]       width,
  input  logic [12:0]       height,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [9:0]        out_column,
  output logic [11:0]       out_row,
  output logic              frame_end
);
  import rbb_pkg::*;
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_READ = 6'b000010, S_ACC = 6'b000100,
    S_DIV  = 6'b001000, S_OUT  = 6'b010000, S_WAIT = 6'b100000
  } state_t;
  state_t state_r;

  logic [23:0] store [StoreDepth];
  logic [23:0] rd_q;
  logic [AddrW-1:0] rd_addr;

  logic [10:0] ex_col_r; logic [12:0] ex_row_r;
  logic [AddrW-1:0] em_addr_r;
  logic signed [4:0] dx_r, dy_r;
  logic [15:0] sr_r, sg_r, sb_r;
  logic [7:0]  cnt_r;
  logic        valid_tap_r, inb;
  logic [7:0]  qr_r, qg_r, qb_r;
  logic [3:0]  bit_r;
  logic [15:0] remr_r, remg_r, remb_r;
  logic signed [13:0] yy, xx;
  logic signed [17:0] off;
  logic signed [AddrW+1:0] tap, tap_fix;
  logic        last;

  assign job_ready = (state_r == S_IDLE);

  always_comb begin
    yy = 14'($signed({1'b0, ex_row_r})) + 14'(dy_r);
    xx = 14'($signed({1'b0, ex_col_r})) + 14'(dx_r);
    inb = (yy >= 0) && (yy < $signed({1'b0, height})) &&
          (xx >= 0) && (xx < $signed({1'b0, width}));
    // The tap sits less than one store depth away from the centre, so one correction wraps it.
    off = 18'(dy_r) * 18'($signed({1'b0, width})) + 18'(dx_r);
    tap = $signed({2'b0, em_addr_r}) + (AddrW+2)'(off);
    if (tap < 0) tap_fix = tap + (AddrW+2)'(StoreDepth);
    else if (tap >= (AddrW+2)'(StoreDepth)) tap_fix = tap - (AddrW+2)'(StoreDepth);
    else tap_fix = tap;
    rd_addr = tap_fix[AddrW-1:0];
    last = (25'(ex_row_r) * 25'(width) + 25'(ex_col_r)) == (25'(width) * 25'(height) - 25'd1);
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready && job.wr) store[job.addr] <= job.pix;
    rd_q <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r <= S_IDLE; ex_col_r <= '0; ex_row_r <= '0; em_addr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (job_valid && job.emit) begin
          dy_r <= -$signed({2'b0, radius}); dx_r <= -$signed({2'b0, radius});
          sr_r <= '0; sg_r <= '0; sb_r <= '0; cnt_r <= '0; valid_tap_r <= 1'b0;
          state_r <= S_READ;
        end
        S_READ: begin
          // A tap's address goes to the store now and its data is accumulated next cycle, before the next tap is read.
          valid_tap_r <= inb;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (valid_tap_r) begin
            sr_r <= sr_r + 16'(rd_q[23:16]); sg_r <= sg_r + 16'(rd_q[15:8]);
            sb_r <= sb_r + 16'(rd_q[7:0]); cnt_r <= cnt_r + 8'd1;
          end
          if (dx_r == $signed({2'b0, radius})) begin
            dx_r <= -$signed({2'b0, radius});
            if (dy_r == $signed({2'b0, radius})) begin
              state_r <= S_DIV; bit_r <= 4'd15;
              remr_r <= '0; remg_r <= '0; remb_r <= '0;
            end else begin
              dy_r <= dy_r + 5'sd1; state_r <= S_READ;
            end
          end else begin
            dx_r <= dx_r + 5'sd1; state_r <= S_READ;
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit a cycle for all three channels.
          logic [15:0] tr, tg, tb;
          tr = {remr_r[14:0], sr_r[bit_r]};
          tg = {remg_r[14:0], sg_r[bit_r]};
          tb = {remb_r[14:0], sb_r[bit_r]};
          if (tr >= 16'(cnt_r)) begin remr_r <= tr - 16'(cnt_r); qr_r <= {qr_r[6:0], 1'b1}; end
          else begin remr_r <= tr; qr_r <= {qr_r[6:0], 1'b0}; end
          if (tg >= 16'(cnt_r)) begin remg_r <= tg - 16'(cnt_r); qg_r <= {qg_r[6:0], 1'b1}; end
          else begin remg_r <= tg; qg_r <= {qg_r[6:0], 1'b0}; end
          if (tb >= 16'(cnt_r)) begin remb_r <= tb - 16'(cnt_r); qb_r <= {qb_r[6:0], 1'b1}; end
          else begin remb_r <= tb; qb_r <= {qb_r[6:0], 1'b0}; end
          if (bit_r == 4'd0) state_r <= S_OUT;
          else bit_r <= bit_r - 4'd1;
        end
        S_OUT: begin
          out_red <= qr_r; out_green <= qg_r; out_blue <= qb_r;
          out_column <= ex_col_r[9:0]; out_row <= ex_row_r[11:0]; frame_end <= last;
          out_valid <= 1'b1; state_r <= S_WAIT;
          if (last) begin
            ex_col_r <= '0; ex_row_r <= '0; em_addr_r <= '0;
          end else begin
            em_addr_r <= (em_addr_r == AddrW'(StoreDepth - 1)) ? '0 : em_addr_r + 1'b1;
            if (ex_col_r + 11'd1 >= width) begin
              ex_col_r <= '0; ex_row_r <= ex_row_r + 13'd1;
            end else ex_col_r <= ex_col_r + 11'd1;
          end
        end
        S_WAIT: if (out_ready) begin
          out_valid <= 1'b0; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
